// File: rtl/core/aes_pkg.sv
// Shared types, constants and stage tables of the energy stage selector.
package aes_pkg;

  localparam int unsigned IN_W  = 104;
  localparam int unsigned OUT_W = 184;

  typedef logic [2:0] stage_t;

  localparam stage_t STG_AMBIENT  = 3'd0;
  localparam stage_t STG_CHILL    = 3'd1;
  localparam stage_t STG_SPECTRUM = 3'd2;
  localparam stage_t STG_PARTY    = 3'd3;
  localparam stage_t STG_EDM      = 3'd4;

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_RELEASE = 2'd1;
  localparam logic [1:0] REG_HOLD    = 2'd2;

  localparam logic [15:0] ATTACK_RST  = 16'd16384;
  localparam logic [15:0] RELEASE_RST = 16'd7864;
  localparam logic [15:0] HOLD_RST    = 16'd3000;

  localparam logic [15:0] ONE_Q15    = 16'd32768;
  localparam logic [15:0] FAC_BASE   = 16'd18022;
  localparam logic [15:0] FAC_SCALE  = 16'd14746;
  localparam logic [15:0] SAT_BEAT   = 16'd3932;
  localparam logic [15:0] SHIFT_BEAT = 16'd1638;
  localparam logic [15:0] RECIP_25   = 16'd41943;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLLOW,
    ST_UPDATE,
    ST_STAGE,
    ST_SCALE,
    ST_DIVIDE,
    ST_FIX,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic follow;
    logic update;
    logic stage;
    logic scale;
    logic divide;
    logic fix;
    logic load_out;
  } dp_cmd_t;

  function automatic logic [15:0] clamp_q15(input logic [15:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  function automatic logic [15:0] lo_thr(input stage_t s);
    case (s)
      STG_AMBIENT:  return 16'd6554;
      STG_CHILL:    return 16'd11141;
      STG_SPECTRUM: return 16'd16384;
      default:      return 16'd21627;
    endcase
  endfunction

  function automatic logic [15:0] hi_thr(input stage_t s);
    case (s)
      STG_AMBIENT:  return 16'd9830;
      STG_CHILL:    return 16'd14418;
      STG_SPECTRUM: return 16'd19661;
      default:      return 16'd24904;
    endcase
  endfunction

  function automatic logic [6:0] st_bright(input stage_t s);
    case (s)
      STG_AMBIENT:  return 7'd45;
      STG_CHILL:    return 7'd62;
      STG_SPECTRUM: return 7'd82;
      STG_PARTY:    return 7'd95;
      default:      return 7'd100;
    endcase
  endfunction

  function automatic logic [15:0] st_sat(input stage_t s);
    case (s)
      STG_AMBIENT:  return 16'd21845;
      STG_CHILL:    return 16'd25700;
      STG_SPECTRUM: return 16'd29555;
      default:      return 16'd32768;
    endcase
  endfunction

  function automatic logic [15:0] st_move(input stage_t s);
    case (s)
      STG_AMBIENT:  return 16'd3932;
      STG_CHILL:    return 16'd7209;
      STG_SPECTRUM: return 16'd12452;
      STG_PARTY:    return 16'd19661;
      default:      return 16'd29491;
    endcase
  endfunction

  function automatic logic [15:0] st_pulse(input stage_t s);
    case (s)
      STG_AMBIENT:  return 16'd3277;
      STG_CHILL:    return 16'd7209;
      STG_SPECTRUM: return 16'd14746;
      STG_PARTY:    return 16'd27853;
      default:      return 16'd32768;
    endcase
  endfunction

  function automatic logic [15:0] st_spark(input stage_t s);
    case (s)
      STG_AMBIENT:  return 16'd1638;
      STG_CHILL:    return 16'd3932;
      STG_SPECTRUM: return 16'd14746;
      STG_PARTY:    return 16'd21299;
      default:      return 16'd29491;
    endcase
  endfunction

  function automatic logic [15:0] st_smooth(input stage_t s);
    case (s)
      STG_AMBIENT:  return 16'd24576;
      STG_CHILL:    return 16'd19661;
      STG_SPECTRUM: return 16'd11469;
      STG_PARTY:    return 16'd7209;
      default:      return 16'd3932;
    endcase
  endfunction

endpackage

// File: rtl/core/aes_ctrl.sv
// Sequencer of the energy stage selector: steps the datapath and owns the output valid.
module aes_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output aes_pkg::dp_cmd_t cmd
);
  import aes_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid;
  logic        out_free;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_FOLLOW;
      ST_FOLLOW: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_STAGE;
      ST_STAGE:  state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_DIVIDE;
      ST_DIVIDE: state_next = ST_FIX;
      ST_FIX:    state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:   cmd.load_in  = s_tvalid;
      ST_FOLLOW: cmd.follow   = 1'b1;
      ST_UPDATE: cmd.update   = 1'b1;
      ST_STAGE:  cmd.stage    = 1'b1;
      ST_SCALE:  cmd.scale    = 1'b1;
      ST_DIVIDE: cmd.divide   = 1'b1;
      ST_FIX:    cmd.fix      = 1'b1;
      ST_DONE:   cmd.load_out = out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a frame is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || m_tready))
    else $error("held result overwritten");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_out_after_fix: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |=> (state == ST_DONE))
    else $error("sequence skipped the result step");

endmodule

// File: rtl/core/aes_dp.sv
// Datapath: input capture, energy follower, stage selection and level scaling.
module aes_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  aes_pkg::dp_cmd_t          cmd,
  input  logic [aes_pkg::IN_W-1:0]  in_data,
  input  logic [15:0]               attack_gain,
  input  logic [15:0]               release_gain,
  input  logic [15:0]               hold_time_ms,
  output logic [aes_pkg::OUT_W-1:0] out_data
);
  import aes_pkg::*;

  // frame registers
  logic [15:0] amp_q;
  logic [15:0] bass_q;
  logic [15:0] mid_q;
  logic [15:0] treble_q;
  logic        beat_q;
  logic [31:0] now_q;

  // persistent state
  logic [15:0] energy;
  stage_t      cur_stage;
  logic [31:0] start_ms;

  // work registers
  logic        up;
  logic [31:0] prod;
  logic [21:0] bx;
  logic [31:0] spark_prod;
  logic [35:0] qprod;
  logic [15:0] bright;

  logic [15:0] d;
  logic [15:0] gain;
  logic [32:0] step_sum;
  logic [15:0] energy_next;
  stage_t      stg;
  stage_t      stage_next;
  logic [31:0] elapsed;
  logic        hold_done;
  logic [31:0] fac_sum;
  logic [15:0] fac;
  logic [19:0] by;
  logic [15:0] q0;
  logic [19:0] rem;
  logic [16:0] sat_sum;
  logic [15:0] sat;
  logic [16:0] pulse_sum;
  logic [15:0] pulse;
  logic [31:0] spark_sum;
  stage_t      s;

  assign d        = (amp_q > energy) ? (amp_q - energy) : (energy - amp_q);
  assign gain     = (amp_q > energy) ? attack_gain : release_gain;
  assign step_sum = {1'b0, prod} + 33'd32768;
  assign energy_next = up ? (energy + step_sum[31:16]) : (energy - step_sum[31:16]);

  assign stg       = (cur_stage > STG_EDM) ? STG_EDM : cur_stage;
  assign elapsed   = now_q - start_ms;
  assign hold_done = (elapsed >= {16'd0, hold_time_ms});

  always_comb begin
    stage_next = stg;
    if (hold_done) begin
      if (stg == STG_EDM) begin
        if (energy < lo_thr(STG_PARTY)) stage_next = STG_AMBIENT;
      end else if (energy < lo_thr(stg)) begin
        stage_next = (stg == STG_AMBIENT) ? STG_AMBIENT : stage_t'(stg - 3'd1);
      end else if (energy > hi_thr(stg)) begin
        stage_next = stage_t'(stg + 3'd1);
      end
    end
  end

  assign s       = cur_stage;
  assign fac_sum = prod + 32'd16384;
  assign fac     = FAC_BASE + fac_sum[30:15];
  assign by      = bx[21:2];
  assign q0      = qprod[35:20];
  assign rem     = by - (20'(q0) * 20'd25);

  assign sat_sum   = {1'b0, st_sat(s)} + (beat_q ? {1'b0, SAT_BEAT} : 17'd0);
  assign sat       = (sat_sum > {1'b0, ONE_Q15}) ? ONE_Q15 : sat_sum[15:0];
  assign pulse_sum = {1'b0, st_pulse(s)} + 17'd2;
  assign pulse     = beat_q ? st_pulse(s) : {2'b00, pulse_sum[15:2]};
  assign spark_sum = spark_prod + 32'd16384;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy    <= '0;
      cur_stage <= STG_AMBIENT;
      start_ms  <= '0;
    end else begin
      if (cmd.update) energy <= energy_next;
      if (cmd.stage) begin
        cur_stage <= stage_next;
        if (stage_next != stg) start_ms <= now_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      amp_q    <= clamp_q15(in_data[15:0]);
      bass_q   <= clamp_q15(in_data[31:16]);
      mid_q    <= clamp_q15(in_data[47:32]);
      treble_q <= clamp_q15(in_data[63:48]);
      beat_q   <= in_data[64];
      now_q    <= in_data[96:65];
    end
    if (cmd.follow) begin
      up   <= (amp_q > energy);
      prod <= 32'(d) * 32'(gain);
    end
    if (cmd.stage) prod <= 32'(FAC_SCALE) * 32'(energy);
    if (cmd.scale) begin
      bx         <= 22'(st_bright(s)) * 22'(fac) + 22'd50;
      spark_prod <= 32'(st_spark(s)) * 32'(treble_q);
    end
    if (cmd.divide) qprod <= 36'(by) * 36'(RECIP_25);
    if (cmd.fix) bright <= (rem >= 20'd25) ? (q0 + 16'd1) : q0;
    if (cmd.load_out) begin
      out_data <= {5'd0,
                   (beat_q ? SHIFT_BEAT : 16'd0),
                   treble_q, mid_q, bass_q,
                   st_smooth(s),
                   spark_sum[30:15],
                   pulse,
                   st_move(s),
                   sat,
                   bright,
                   energy,
                   s};
    end
  end

  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    cur_stage <= STG_EDM)
    else $error("stage code out of range");

  a_energy_range: assert property (@(posedge clk) disable iff (rst)
    energy <= ONE_Q15)
    else $error("energy above full scale");

  a_stage_one_step: assert property (@(posedge clk) disable iff (rst)
    cmd.stage |=> (cur_stage == $past(stg)) || (cur_stage == STG_AMBIENT)
                  || (cur_stage == stage_t'($past(stg) + 3'd1))
                  || (cur_stage == stage_t'($past(stg) - 3'd1)))
    else $error("stage jumped more than one step");

endmodule

// File: rtl/core/auto_energy_stage_selector_core.sv
// Top level of the energy stage selector: configuration registers, sequencer and datapath.
//
// One input beat carries an analysis frame (amplitude, bass, mid, treble, beat flag,
// millisecond time); one output beat carries the selected stage and its lighting levels.
// Both sides are valid/ready streams; a beat moves when tvalid and tready are high.
// The APB port holds attack gain, release gain and hold time at byte addresses 0, 4, 8;
// writes complete in the access cycle, pready is always high.
// Frames are taken one at a time, a new one only once the eight-step sequencer that walks
// the follower, stage decision, scaling and the divide-by-100 correction is back in idle.
// Reset (synchronous, rst high): energy, stage and stage timer clear to zero, the
// registers take their defaults, no result is pending.
// When the receiver stalls, the result is held in the output register; one more frame
// is taken and worked on, and it waits in its last step until the held result leaves.
module auto_energy_stage_selector_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // amplitude[15:0], bass[31:16], mid[47:32], treble[63:48], beat[64], now_ms[96:65]
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // stage[2:0], intensity[18:3], brightness[34:19], colour_saturation[50:35],
  // movement[66:51], pulse[82:67], sparkle[98:83], smoothing[114:99],
  // bass_level[130:115], mid_level[146:131], treble_level[162:147],
  // colour_shift[178:163]
  output logic [183:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import aes_pkg::*;

  logic [15:0] attack_gain;
  logic [15:0] release_gain;
  logic [15:0] hold_time_ms;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  dp_cmd_t     cmd;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_gain  <= ATTACK_RST;
      release_gain <= RELEASE_RST;
      hold_time_ms <= HOLD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ATTACK:  attack_gain  <= pwdata[15:0];
        REG_RELEASE: release_gain <= pwdata[15:0];
        REG_HOLD:    hold_time_ms <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ATTACK:  prdata = {16'd0, attack_gain};
      REG_RELEASE: prdata = {16'd0, release_gain};
      REG_HOLD:    prdata = {16'd0, hold_time_ms};
      default:     prdata = 32'd0;
    endcase
  end

  aes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  aes_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_data      (s_tdata),
    .attack_gain  (attack_gain),
    .release_gain (release_gain),
    .hold_time_ms (hold_time_ms),
    .out_data     (m_tdata)
  );

endmodule
